// ===== src/apc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

  localparam int unsigned MSG_W   = 48;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DAMP_W  = 16;
  localparam int unsigned CFG_W   = 16;

  typedef logic signed [MSG_W-1:0] msg_t;

  typedef enum logic [1:0] {
    CFG_POINTS = 2'd0,
    CFG_DIMS   = 2'd1,
    CFG_ITERS  = 2'd2,
    CFG_DAMP   = 2'd3
  } cfg_idx_e;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic signed [63:0] MSG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MSG_MIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

  function automatic msg_t sat_msg(input logic signed [63:0] v);
    msg_t r;
    if (v > MSG_MAX) begin
      r = MSG_MAX[MSG_W-1:0];
    end else if (v < MSG_MIN) begin
      r = MSG_MIN[MSG_W-1:0];
    end else begin
      r = v[MSG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/affinity_propagation_clusterer_top.sv =====
// affinity propagation clusterer
// slave stream: one beat per item; tuser is the kind (0 load, 1 run), tdata the
// signed 16-bit coordinate. load beats fill coordinates point by point, dimension
// by dimension, one per cycle; surplus loads past n*d are dropped.
// a run beat builds the similarity matrix, the preference (mean off-diagonal
// similarity, via a one-bit-per-cycle divider), then runs the configured number
// of damped responsibility/availability sweeps and emits one label beat per point.
// master stream: tdata = point index [4:0], exemplar [9:5]; tlast on point n-1.
// each message update goes read, compute, multiply, write (the _RD and _CALC states,
// then S_DMUL and S_DWR); the s, r and a memories share one read and one write address.
// tready stays low for the whole run.
// a stalled master holds the label beat and the sweep waits for it.
// reset clears control state and loads registers (32, 8, 200, 32768); message memories
// are cleared by the similarity sweep of each run, coordinates are undefined until
// loaded. configuration writes go through cfg_we_i/cfg_idx_i/cfg_data_i, no wait.
`timescale 1ns / 1ps
`default_nettype none

module affinity_propagation_clusterer_top #(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned MAX_DIMS   = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [apc_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [15:0]                s_axis_tdata,   // coordinate
  input  wire logic                       s_axis_tuser,   // kind
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // point_index, exemplar, zero pad
  output logic                            m_axis_tlast
);

  localparam int unsigned MW   = apc_pkg::MSG_W;
  localparam int unsigned PW   = $clog2(MAX_POINTS);
  localparam int unsigned NW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DNW  = $clog2(MAX_DIMS + 1);
  localparam int unsigned AW   = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int unsigned LW   = $clog2(MAX_POINTS * MAX_DIMS + 1);
  localparam int unsigned CDEP = MAX_POINTS * MAX_DIMS;
  localparam int unsigned MDEP = 1 << (2 * PW);
  localparam int unsigned DW   = 32 + $clog2(MAX_DIMS);
  localparam int unsigned TW   = MW + 2 * PW;
  localparam int unsigned QW   = 2 * NW;
  localparam int unsigned KW   = $clog2(TW + 1);
  localparam int unsigned PSW  = MW + PW;
  localparam int unsigned EW   = PSW + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_SIM_RD, S_SIM_MUL, S_SIM_ACC, S_SIM_WR, S_DIV, S_PREF,
    S_RM_RD, S_RM_ACC, S_RR_RD, S_RR_CALC, S_AS_RD, S_AS_ACC, S_AU_RD,
    S_AU_CALC, S_DMUL, S_DWR, S_LB_RD, S_LB_ACC, S_EMIT
  } state_e;

  state_e state_q;

  logic [5:0]  pu_q;
  logic [3:0]  dm_q;
  logic [9:0]  iter_q;
  logic [15:0] damp_q;

  logic [NW-1:0]  n;
  logic [PW-1:0]  n_m1;
  logic [DNW-1:0] d;
  logic [CW-1:0]  d_m1;
  logic [LW-1:0]  nd;
  logic [QW-1:0]  den;

  always_comb begin
    if (32'(pu_q) < 2) begin
      n = NW'(2);
    end else if (32'(pu_q) > MAX_POINTS) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(pu_q);
    end
    if (32'(dm_q) < 1) begin
      d = DNW'(1);
    end else if (32'(dm_q) > MAX_DIMS) begin
      d = DNW'(MAX_DIMS);
    end else begin
      d = DNW'(dm_q);
    end
  end

  assign n_m1 = PW'(n - NW'(1));
  assign d_m1 = CW'(d - DNW'(1));
  assign nd   = LW'(n) * LW'(d);
  assign den  = QW'(n) * QW'(n - NW'(1));

  // counters and working registers
  logic [LW-1:0]       lp_q;
  logic [PW-1:0]       i_q, k_q, j_q;
  logic [CW-1:0]       c_q;
  logic [AW-1:0]       base_i_q, base_k_q;
  logic [31:0]         sq_q;
  logic [DW-1:0]       dist_q;
  logic [TW-1:0]       total_q, quo_q;
  logic [QW-1:0]       rem_q;
  logic [KW-1:0]       div_cnt_q;
  logic [9:0]          it_q;
  logic signed [MW:0]  mx1_q, mx2_q, best_q;
  logic [PW-1:0]       mx_idx_q, bk_q;
  logic signed [PSW-1:0] pos_q;
  apc_pkg::msg_t       rkk_q, old_q, fresh_q;
  logic                dst_a_q;
  logic signed [64:0]  p1_q;
  logic signed [65:0]  p2_q;
  logic                mvalid_q, mlast_q;
  logic [PW-1:0]       out_pi_q, out_ex_q;

  // memories
  logic [apc_pkg::COORD_W-1:0] c_mem [CDEP];
  apc_pkg::msg_t s_mem [MDEP];
  apc_pkg::msg_t r_mem [MDEP];
  apc_pkg::msg_t a_mem [MDEP];
  logic signed [apc_pkg::COORD_W-1:0] ca_rd_q, cb_rd_q;
  apc_pkg::msg_t s_rd_q, r_rd_q, a_rd_q;

  logic [AW-1:0]   ca_addr, cb_addr;
  logic            c_we;
  logic [2*PW-1:0] mr_addr, mw_addr;
  logic            s_we, r_we, a_we;
  apc_pkg::msg_t   s_wd, r_wd, a_wd;

  assign ca_addr = base_i_q + AW'(c_q);
  assign cb_addr = base_k_q + AW'(c_q);
  assign c_we    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == apc_pkg::KIND_LOAD)
                   && (lp_q < nd);

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[lp_q[AW-1:0]] <= s_axis_tdata;
    end
    ca_rd_q <= c_mem[ca_addr];
    cb_rd_q <= c_mem[cb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[mw_addr] <= s_wd;
    end
    s_rd_q <= s_mem[mr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      r_mem[mw_addr] <= r_wd;
    end
    r_rd_q <= r_mem[mr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[mw_addr] <= a_wd;
    end
    a_rd_q <= a_mem[mr_addr];
  end

  // datapath
  logic signed [16:0]   diff;
  logic signed [33:0]   diff_sq;
  logic [TW-1:0]        total_nx;
  logic [QW:0]          rem_sh, rem_sub;
  logic                 q_bit;
  apc_pkg::msg_t        sim_val, pref_val, damp_res;
  logic signed [MW:0]   v_as, v_ar;
  logic signed [MW:0]   rbest;
  logic signed [MW+1:0] rdiff;
  apc_pkg::msg_t        rpos;
  logic signed [EW-1:0] ax;
  apc_pkg::msg_t        a_fresh;
  logic [16:0]          wn;
  logic signed [66:0]   dsum;
  logic                 lb_take;

  always_comb begin
    diff     = 17'(ca_rd_q) - 17'(cb_rd_q);
    diff_sq  = diff * diff;
    sim_val  = -(MW'({dist_q, 8'b0}));
    total_nx = total_q + TW'({dist_q, 8'b0});
    rem_sh   = {rem_q, quo_q[TW-1]};
    rem_sub  = rem_sh - {1'b0, den};
    q_bit    = (rem_sh >= {1'b0, den});
    pref_val = -(MW'(quo_q));
    v_as     = (MW+1)'(a_rd_q) + (MW+1)'(s_rd_q);
    v_ar     = (MW+1)'(a_rd_q) + (MW+1)'(r_rd_q);
    rbest    = (k_q == mx_idx_q) ? mx2_q : mx1_q;
    rdiff    = (MW+2)'(s_rd_q) - (MW+2)'(rbest);
    rpos     = (r_rd_q > 0) ? r_rd_q : '0;
    ax       = EW'(rkk_q) + EW'(pos_q) - EW'(rpos);
    if (ax > 0) begin
      ax = '0;
    end
    if (i_q == k_q) begin
      a_fresh = apc_pkg::sat_msg(64'(pos_q));
    end else begin
      a_fresh = apc_pkg::sat_msg(64'(ax));
    end
    wn       = 17'(17'h10000 - {1'b0, damp_q});
    dsum     = 67'(p1_q) + 67'(p2_q);
    damp_res = dsum[MW+15:16];
    lb_take  = (k_q == '0) || (v_ar > best_q);
  end

  always_comb begin
    mr_addr = {i_q, k_q};
    mw_addr = {i_q, k_q};
    s_we = 1'b0;
    r_we = 1'b0;
    a_we = 1'b0;
    s_wd = sim_val;
    r_wd = '0;
    a_wd = '0;
    unique case (state_q)
      S_RM_RD: mr_addr = {i_q, j_q};
      S_AS_RD: mr_addr = {j_q, k_q};
      S_SIM_WR: begin
        s_we = 1'b1;
        r_we = 1'b1;
        a_we = 1'b1;
      end
      S_PREF: begin
        mw_addr = {i_q, i_q};
        s_we    = 1'b1;
        s_wd    = pref_val;
      end
      S_DWR: begin
        r_we = !dst_a_q;
        a_we = dst_a_q;
        r_wd = damp_res;
        a_wd = damp_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pu_q   <= 6'd32;
      dm_q   <= 4'd8;
      iter_q <= 10'd200;
      damp_q <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (apc_pkg::cfg_idx_e'(cfg_idx_i))
        apc_pkg::CFG_POINTS: pu_q   <= cfg_data_i[5:0];
        apc_pkg::CFG_DIMS:   dm_q   <= cfg_data_i[3:0];
        apc_pkg::CFG_ITERS:  iter_q <= cfg_data_i[9:0];
        apc_pkg::CFG_DAMP:   damp_q <= cfg_data_i[15:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lp_q      <= '0;
      mvalid_q  <= 1'b0;
      mlast_q   <= 1'b0;
      i_q       <= '0;
      k_q       <= '0;
      j_q       <= '0;
      c_q       <= '0;
      base_i_q  <= '0;
      base_k_q  <= '0;
      it_q      <= '0;
      div_cnt_q <= '0;
      dst_a_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == apc_pkg::KIND_RUN) begin
              lp_q     <= '0;
              i_q      <= '0;
              k_q      <= '0;
              c_q      <= '0;
              base_i_q <= '0;
              base_k_q <= '0;
              dist_q   <= '0;
              total_q  <= '0;
              state_q  <= S_SIM_RD;
            end else if (lp_q < nd) begin
              lp_q <= lp_q + LW'(1);
            end
          end
        end
        S_SIM_RD: state_q <= S_SIM_MUL;
        S_SIM_MUL: begin
          sq_q    <= diff_sq[31:0];
          state_q <= S_SIM_ACC;
        end
        S_SIM_ACC: begin
          dist_q <= dist_q + DW'(sq_q);
          if (c_q == d_m1) begin
            c_q     <= '0;
            state_q <= S_SIM_WR;
          end else begin
            c_q     <= c_q + CW'(1);
            state_q <= S_SIM_RD;
          end
        end
        S_SIM_WR: begin
          total_q <= total_nx;
          dist_q  <= '0;
          state_q <= S_SIM_RD;
          if (k_q == n_m1) begin
            k_q      <= '0;
            base_k_q <= '0;
            if (i_q == n_m1) begin
              rem_q     <= '0;
              quo_q     <= total_nx;
              div_cnt_q <= KW'(TW);
              state_q   <= S_DIV;
            end else begin
              i_q      <= i_q + PW'(1);
              base_i_q <= base_i_q + AW'(d);
            end
          end else begin
            k_q      <= k_q + PW'(1);
            base_k_q <= base_k_q + AW'(d);
          end
        end
        S_DIV: begin
          rem_q     <= q_bit ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
          quo_q     <= {quo_q[TW-2:0], q_bit};
          div_cnt_q <= div_cnt_q - KW'(1);
          if (div_cnt_q == KW'(1)) begin
            i_q     <= '0;
            state_q <= S_PREF;
          end
        end
        S_PREF: begin
          if (i_q == n_m1) begin
            i_q <= '0;
            k_q <= '0;
            j_q <= '0;
            it_q <= '0;
            mx1_q    <= {1'b1, {MW{1'b0}}};
            mx2_q    <= {1'b1, {MW{1'b0}}};
            mx_idx_q <= '0;
            state_q  <= (iter_q == '0) ? S_LB_RD : S_RM_RD;
          end else begin
            i_q <= i_q + PW'(1);
          end
        end
        S_RM_RD: state_q <= S_RM_ACC;
        S_RM_ACC: begin
          if (v_as > mx1_q) begin
            mx2_q    <= mx1_q;
            mx1_q    <= v_as;
            mx_idx_q <= j_q;
          end else if (v_as > mx2_q) begin
            mx2_q <= v_as;
          end
          if (j_q == n_m1) begin
            j_q     <= '0;
            k_q     <= '0;
            state_q <= S_RR_RD;
          end else begin
            j_q     <= j_q + PW'(1);
            state_q <= S_RM_RD;
          end
        end
        S_RR_RD: state_q <= S_RR_CALC;
        S_RR_CALC: begin
          fresh_q <= apc_pkg::sat_msg(64'(rdiff));
          old_q   <= r_rd_q;
          dst_a_q <= 1'b0;
          state_q <= S_DMUL;
        end
        S_AS_RD: state_q <= S_AS_ACC;
        S_AS_ACC: begin
          if (j_q == k_q) begin
            rkk_q <= r_rd_q;
          end else if (r_rd_q > 0) begin
            pos_q <= pos_q + PSW'(r_rd_q);
          end
          if (j_q == n_m1) begin
            j_q     <= '0;
            i_q     <= '0;
            state_q <= S_AU_RD;
          end else begin
            j_q     <= j_q + PW'(1);
            state_q <= S_AS_RD;
          end
        end
        S_AU_RD: state_q <= S_AU_CALC;
        S_AU_CALC: begin
          fresh_q <= a_fresh;
          old_q   <= a_rd_q;
          dst_a_q <= 1'b1;
          state_q <= S_DMUL;
        end
        S_DMUL: begin
          p1_q    <= $signed({1'b0, damp_q}) * old_q;
          p2_q    <= $signed({1'b0, wn}) * fresh_q;
          state_q <= S_DWR;
        end
        S_DWR: begin
          if (!dst_a_q) begin
            if (k_q == n_m1) begin
              k_q <= '0;
              if (i_q == n_m1) begin
                i_q     <= '0;
                j_q     <= '0;
                pos_q   <= '0;
                rkk_q   <= '0;
                state_q <= S_AS_RD;
              end else begin
                i_q      <= i_q + PW'(1);
                j_q      <= '0;
                mx1_q    <= {1'b1, {MW{1'b0}}};
                mx2_q    <= {1'b1, {MW{1'b0}}};
                mx_idx_q <= '0;
                state_q  <= S_RM_RD;
              end
            end else begin
              k_q     <= k_q + PW'(1);
              state_q <= S_RR_RD;
            end
          end else begin
            if (i_q == n_m1) begin
              i_q <= '0;
              j_q <= '0;
              if (k_q == n_m1) begin
                k_q      <= '0;
                mx1_q    <= {1'b1, {MW{1'b0}}};
                mx2_q    <= {1'b1, {MW{1'b0}}};
                mx_idx_q <= '0;
                if (it_q == iter_q - 10'd1) begin
                  state_q <= S_LB_RD;
                end else begin
                  it_q    <= it_q + 10'd1;
                  state_q <= S_RM_RD;
                end
              end else begin
                k_q     <= k_q + PW'(1);
                pos_q   <= '0;
                rkk_q   <= '0;
                state_q <= S_AS_RD;
              end
            end else begin
              i_q     <= i_q + PW'(1);
              state_q <= S_AU_RD;
            end
          end
        end
        S_LB_RD: state_q <= S_LB_ACC;
        S_LB_ACC: begin
          if (lb_take) begin
            best_q <= v_ar;
            bk_q   <= k_q;
          end
          if (k_q == n_m1) begin
            out_pi_q <= i_q;
            out_ex_q <= lb_take ? k_q : bk_q;
            mlast_q  <= (i_q == n_m1);
            mvalid_q <= 1'b1;
            state_q  <= S_EMIT;
          end else begin
            k_q     <= k_q + PW'(1);
            state_q <= S_LB_RD;
          end
        end
        S_EMIT: begin
          if (m_axis_tready) begin
            mvalid_q <= 1'b0;
            k_q      <= '0;
            if (mlast_q) begin
              i_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + PW'(1);
              state_q <= S_LB_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [PW+4:0] pi_ext, ex_ext;
  assign pi_ext = (PW+5)'(out_pi_q);
  assign ex_ext = (PW+5)'(out_ex_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {6'b0, ex_ext[4:0], pi_ext[4:0]};
  assign m_axis_tlast  = mlast_q;

  a_busy_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a label beat is pending");

  a_last_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (out_pi_q == n_m1))
    else $error("tlast on a point other than n-1");

  a_exemplar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_ex_q <= n_m1))
    else $error("exemplar outside the point range");

  a_div_to_pref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_cnt_q == KW'(1)) |=> (state_q == S_PREF))
    else $error("divider did not hand over to preference write");

endmodule

`default_nettype wire

// ===== test/affinity_propagation_clusterer_top_test.sv =====
`timescale 1ns / 1ps

module affinity_propagation_clusterer_top_test;

  localparam int NPTS = 32;
  localparam int NDIM = 8;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic [4:0] idx;
    logic [4:0] ex;
    logic       last;
  } label_t;

  typedef struct {
    int pts;
    int dms;
    int its;
    int dmp;
    int extra;
    int mode;
    int known_ex;
  } phase_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [1:0]                cfg_idx_i = '0;
  logic [apc_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata = '0;
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [15:0]               m_axis_tdata;
  logic                      m_axis_tlast;

  affinity_propagation_clusterer_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata,  // coordinate
    .s_axis_tuser,  // kind
    .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata,  // point_index [4:0], exemplar [9:5]
    .m_axis_tlast
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  shortint coords[NPTS*NDIM];
  int      load_pos;
  int      reg_pts, reg_dms, reg_its, reg_dmp;
  longint  sim[NPTS][NPTS];
  longint  resp[NPTS][NPTS];
  longint  avail[NPTS][NPTS];
  label_t  labels_q[$];

  int errors = 0;
  int labels_seen = 0;
  int runs_done = 0;
  int items_sent = 0;
  int written_hi = 0;
  int burst_left = 0;
  int known_ex = -1;
  shortint ctr[4][NDIM];

  function automatic int eff_points();
    return reg_pts < 2 ? 2 : (reg_pts > NPTS ? NPTS : reg_pts);
  endfunction

  function automatic int eff_dims();
    return reg_dms < 1 ? 1 : (reg_dms > NDIM ? NDIM : reg_dms);
  endfunction

  function automatic longint sat_val(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< 47) - 1;
    lo = -(64'sd1 <<< 47);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint damp_msg(longint old, longint fresh);
    longint w;
    w = reg_dmp;
    return (w * old + (65536 - w) * fresh) >>> 16;
  endfunction

  function automatic void cluster_run();
    int n, d;
    longint total, sq_dist, diff, best, v, pos, rkk, rik, fresh;
    bit seen;
    label_t lb;
    n = eff_points();
    d = eff_dims();
    total = 0;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < n; k++) begin
        sq_dist = 0;
        for (int c = 0; c < d; c++) begin
          diff = longint'(coords[i*d+c]) - longint'(coords[k*d+c]);
          sq_dist += diff * diff;
        end
        sq_dist = sq_dist <<< 8;
        sim[i][k] = -sq_dist;
        if (i != k) total += sq_dist;
        resp[i][k] = 0;
        avail[i][k] = 0;
      end
    end
    for (int i = 0; i < n; i++) sim[i][i] = -(total / (n * (n - 1)));
    for (int it = 0; it < reg_its; it++) begin
      for (int i = 0; i < n; i++) begin
        for (int k = 0; k < n; k++) begin
          seen = 0;
          best = 0;
          for (int j = 0; j < n; j++) begin
            if (j != k) begin
              v = avail[i][j] + sim[i][j];
              if (!seen || v > best) begin
                best = v;
                seen = 1;
              end
            end
          end
          resp[i][k] = damp_msg(resp[i][k], sat_val(sim[i][k] - best));
        end
      end
      for (int k = 0; k < n; k++) begin
        pos = 0;
        rkk = resp[k][k];
        for (int j = 0; j < n; j++) if (j != k && resp[j][k] > 0) pos += resp[j][k];
        for (int i = 0; i < n; i++) begin
          if (i == k) begin
            fresh = pos;
          end else begin
            rik = resp[i][k];
            fresh = rkk + pos - (rik > 0 ? rik : 0);
            if (fresh > 0) fresh = 0;
          end
          avail[i][k] = damp_msg(avail[i][k], sat_val(fresh));
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      lb.ex = '0;
      best = 0;
      for (int k = 0; k < n; k++) begin
        v = avail[i][k] + resp[i][k];
        if (k == 0 || v > best) begin
          best = v;
          lb.ex = k[4:0];
        end
      end
      if (known_ex >= 0) lb.ex = known_ex[4:0];
      lb.idx = i[4:0];
      lb.last = (i == n - 1);
      labels_q.push_back(lb);
    end
  endfunction

  function automatic void predict_item(logic kind, logic [15:0] coord);
    if (kind == apc_pkg::KIND_LOAD) begin
      if (load_pos < eff_points() * eff_dims()) begin
        coords[load_pos] = coord;
        load_pos++;
      end
    end else begin
      load_pos = 0;
      cluster_run();
      runs_done++;
    end
  endfunction

  task automatic send_beat(logic kind, logic [15:0] coord);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= coord;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(kind, coord);
    items_sent++;
  endtask

  task automatic write_regs(int pts, int dms, int its, int dmp);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= apc_pkg::CFG_POINTS;
    cfg_data_i <= apc_pkg::CFG_W'(pts);
    @(posedge clk_i);
    cfg_idx_i <= apc_pkg::CFG_DIMS;
    cfg_data_i <= apc_pkg::CFG_W'(dms);
    @(posedge clk_i);
    cfg_idx_i <= apc_pkg::CFG_ITERS;
    cfg_data_i <= apc_pkg::CFG_W'(its);
    @(posedge clk_i);
    cfg_idx_i <= apc_pkg::CFG_DAMP;
    cfg_data_i <= apc_pkg::CFG_W'(dmp);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_pts = pts & 6'h3f;
    reg_dms = dms & 4'hf;
    reg_its = its & 10'h3ff;
    reg_dmp = dmp & 16'hffff;
  endtask

  function automatic logic [15:0] make_coord(int mode, int pos, int d);
    case (mode)
      1: return pos[0] ? 16'h8000 : 16'h7fff;
      2: return 16'h0000;
      3: return 16'(ctr[(pos / d) % 4][pos % d] + $signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(phase_t ph);
    int total, nload;
    write_regs(ph.pts, ph.dms, ph.its, ph.dmp);
    for (int p = 0; p < 4; p++)
      for (int c = 0; c < NDIM; c++) ctr[p][c] = shortint'($urandom_range(0, 40000)) - 20000;
    total = eff_points() * eff_dims();
    nload = total + ph.extra;
    if (ph.extra < 0) nload = (total <= written_hi) ? -ph.extra - 1 : total;
    for (int i = 0; i < nload; i++)
      send_beat(apc_pkg::KIND_LOAD, make_coord(ph.mode, i, eff_dims()));
    if (nload > written_hi) written_hi = nload > total ? total : nload;
    known_ex = ph.known_ex;
    send_beat(apc_pkg::KIND_RUN, 16'($urandom));
    known_ex = -1;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (labels_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // receiver stall pattern
  int rx_cnt = 0;
  int rx_mode = 0;
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 64 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    label_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      labels_seen++;
      if (labels_q.size() == 0) begin
        $error("label beat with nothing expected: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = labels_q.pop_front();
        if (m_axis_tdata[4:0] !== want.idx) begin
          $error("point_index expected %0d got %0d", want.idx, m_axis_tdata[4:0]);
          errors++;
        end
        if (m_axis_tdata[9:5] !== want.ex) begin
          $error("exemplar expected %0d got %0d", want.ex, m_axis_tdata[9:5]);
          errors++;
        end
        if (m_axis_tdata[15:10] !== '0) begin
          $error("pad expected 0 got %h", m_axis_tdata[15:10]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last expected %0b got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d labels outstanding", labels_q.size());
      $display("affinity_propagation_clusterer_top_test NOT OK");
      $finish;
    end
  end

  phase_t directed[5] = '{
    '{pts: 2,  dms: 1,  its: 1,    dmp: 0,     extra: 2, mode: 1, known_ex: -1},
    '{pts: 0,  dms: 0,  its: 0,    dmp: 12345, extra: -1, mode: 0, known_ex: 0},
    '{pts: 2,  dms: 1,  its: 1023, dmp: 65535, extra: 0, mode: 2, known_ex: -1},
    '{pts: 3,  dms: 9,  its: 3,    dmp: 40000, extra: 0, mode: 3, known_ex: -1},
    '{pts: 33, dms: 1,  its: 2,    dmp: 32768, extra: 0, mode: 3, known_ex: -1}
  };

  initial begin
    phase_t ph;
    int r;
    load_pos = 0;
    reg_pts = 32;
    reg_dms = 8;
    reg_its = 200;
    reg_dmp = 32768;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    foreach (directed[i]) run_phase(directed[i]);
    while (items_sent < 470) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        ph.pts = $urandom_range(0, 63);
        ph.dms = $urandom_range(0, 15);
        ph.its = $urandom_range(0, 2);
      end else begin
        ph.pts = $urandom_range(2, 6);
        ph.dms = $urandom_range(1, 3);
        ph.its = $urandom_range(1, 40);
      end
      case ($urandom_range(0, 5))
        0: ph.dmp = 0;
        1: ph.dmp = 65535;
        default: ph.dmp = $urandom_range(0, 65535);
      endcase
      r = $urandom_range(0, 19);
      if (r < 3) ph.extra = $urandom_range(1, 4);
      else if (r < 5) ph.extra = -$urandom_range(1, 4);
      else ph.extra = 0;
      ph.mode = ($urandom_range(0, 1) == 0) ? 3 : $urandom_range(0, 1);
      ph.known_ex = -1;
      run_phase(ph);
    end
    repeat (50) @(posedge clk_i);
    if (labels_q.size() != 0) begin
      $error("%0d labels never arrived", labels_q.size());
      errors++;
    end
    $display("covered %0d input beats over %0d clustering runs, %0d label beats checked",
             items_sent, runs_done, labels_seen);
    if (errors == 0) begin
      $display("affinity_propagation_clusterer_top_test OK");
    end else begin
      $display("affinity_propagation_clusterer_top_test NOT OK");
    end
    $finish;
  end

endmodule
